@@ hdl/jss_pkg.sv @@
// ----------------------------------------------------------------------------
// jss_pkg: shared types and constants of the JTAG shift sequencer
// Holds the command codes, the input and result word layouts, and the fixed
// lengths used by the shift engine.
// ----------------------------------------------------------------------------
package jss_pkg;

    localparam int unsigned DR_LENGTH   = 32;
    localparam int unsigned COUNT_W     = 24;
    localparam int unsigned ERASE_RESET = 360000;

    localparam logic [2:0] CMD_LSB_SHIFT = 3'd0;
    localparam logic [2:0] CMD_MSB_SHIFT = 3'd1;
    localparam logic [2:0] CMD_TMS_SHIFT = 3'd2;
    localparam logic [2:0] CMD_MSB_OUT   = 3'd3;
    localparam logic [2:0] CMD_DR32      = 3'd4;
    localparam logic [2:0] CMD_ERASE     = 3'd5;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  command;
        logic [7:0]  data;
        logic [3:0]  bit_count;
        logic [31:0] dr_word;
        logic [7:0]  tail;
        logic        tdo;
    } t_item;

    typedef struct packed {
        logic       clocked;
        logic       tdi_out;
        logic       tms_out;
        logic       done_res;
        logic [7:0] reply;
    } t_result;

endpackage

@@ hdl/jss_engine.sv @@
// ----------------------------------------------------------------------------
// jss_engine: command state and per-word shift step
// Holds the active command, the clock count and the shift registers, and
// works out the pin levels and reply for one word combinationally.
// ----------------------------------------------------------------------------
module jss_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  jss_pkg::t_item                      i_item,
    input  logic [jss_pkg::COUNT_W-1:0]         i_erase_clocks,
    output logic                                o_res_valid,
    output jss_pkg::t_result                    o_res
);

    logic [2:0]                     r_mode, n_mode;
    logic                           r_busy, n_busy;
    logic [jss_pkg::COUNT_W-1:0]    r_clocks_left, n_clocks_left;
    logic [jss_pkg::DR_LENGTH-1:0]  r_out_shift, n_out_shift;
    logic [7:0]                     r_capture, n_capture;
    logic                           r_last_tms, n_last_tms;
    logic                           r_tdi, n_tdi;
    logic                           r_tms, n_tms;
    logic [jss_pkg::COUNT_W-1:0]    w_count;
    logic                           w_done;

    always_comb begin
        n_mode        = r_mode;
        n_busy        = r_busy;
        n_clocks_left = r_clocks_left;
        n_out_shift   = r_out_shift;
        n_capture     = r_capture;
        n_last_tms    = r_last_tms;
        n_tdi         = r_tdi;
        n_tms         = r_tms;
        w_count       = {{(jss_pkg::COUNT_W-4){1'b0}}, i_item.bit_count};
        w_done        = (r_clocks_left == jss_pkg::COUNT_W'(1));
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_item.operation == jss_pkg::OP_START) begin
            // drop starts while busy and unknown commands
            if (!r_busy && i_item.command <= jss_pkg::CMD_ERASE) begin
                n_capture   = '0;
                n_out_shift = {{(jss_pkg::DR_LENGTH-8){1'b0}}, i_item.data};
                case (i_item.command)
                    jss_pkg::CMD_TMS_SHIFT: begin
                        n_tdi = i_item.data[7];
                    end
                    jss_pkg::CMD_DR32: begin
                        // bytes 0..2 first, then byte 3 bits 7..1, then tail bit 7
                        n_out_shift = {i_item.dr_word[7:0], i_item.dr_word[15:8],
                                       i_item.dr_word[23:16], i_item.dr_word[31:25],
                                       i_item.tail[7]};
                        n_last_tms  = i_item.tail[0];
                        w_count     = jss_pkg::COUNT_W'(jss_pkg::DR_LENGTH);
                    end
                    jss_pkg::CMD_ERASE: begin
                        n_tdi   = 1'b0;
                        n_tms   = 1'b0;
                        w_count = i_erase_clocks;
                    end
                    default: begin
                    end
                endcase
                n_mode        = i_item.command;
                n_clocks_left = w_count;
                n_busy        = (w_count != '0);
            end
        end else if (r_busy) begin
            case (r_mode)
                jss_pkg::CMD_LSB_SHIFT: begin
                    n_tdi       = r_out_shift[0];
                    n_out_shift = {{(jss_pkg::DR_LENGTH-7){1'b0}}, r_out_shift[7:1]};
                    n_capture   = {i_item.tdo, r_capture[7:1]};
                end
                jss_pkg::CMD_MSB_SHIFT: begin
                    n_tdi       = r_out_shift[7];
                    n_out_shift = {{(jss_pkg::DR_LENGTH-8){1'b0}}, r_out_shift[6:0], 1'b0};
                    n_capture   = {r_capture[6:0], i_item.tdo};
                end
                jss_pkg::CMD_TMS_SHIFT: begin
                    n_tms       = r_out_shift[0];
                    n_out_shift = {{(jss_pkg::DR_LENGTH-7){1'b0}}, r_out_shift[7:1]};
                    n_capture   = {i_item.tdo, r_capture[7:1]};
                end
                jss_pkg::CMD_MSB_OUT: begin
                    n_tdi       = r_out_shift[7];
                    n_out_shift = {{(jss_pkg::DR_LENGTH-8){1'b0}}, r_out_shift[6:0], 1'b0};
                end
                jss_pkg::CMD_DR32: begin
                    n_tdi       = r_out_shift[jss_pkg::DR_LENGTH-1];
                    n_out_shift = {r_out_shift[jss_pkg::DR_LENGTH-2:0], 1'b0};
                    n_tms       = w_done ? r_last_tms : 1'b0;
                end
                default: begin
                    n_tdi = 1'b0;
                    n_tms = 1'b0;
                end
            endcase
            n_clocks_left = r_clocks_left - jss_pkg::COUNT_W'(1);
            if (w_done) begin
                n_busy = 1'b0;
            end

            o_res_valid      = 1'b1;
            o_res.clocked    = 1'b1;
            o_res.tdi_out    = n_tdi;
            o_res.tms_out    = n_tms;
            o_res.done_res   = w_done;
            o_res.reply      = (w_done && r_mode <= jss_pkg::CMD_TMS_SHIFT) ? n_capture : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_busy        <= 1'b0;
            r_clocks_left <= '0;
            r_out_shift   <= '0;
            r_capture     <= '0;
            r_last_tms    <= 1'b0;
            r_tdi         <= 1'b0;
            r_tms         <= 1'b0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_busy        <= n_busy;
            r_clocks_left <= n_clocks_left;
            r_out_shift   <= n_out_shift;
            r_capture     <= n_capture;
            r_last_tms    <= n_last_tms;
            r_tdi         <= n_tdi;
            r_tms         <= n_tms;
        end
    end

endmodule

@@ hdl/jss_out_reg.sv @@
// ----------------------------------------------------------------------------
// jss_out_reg: result register of the shift sequencer
// Holds one result word for the downstream side and tells the engine when
// it may advance.
// ----------------------------------------------------------------------------
module jss_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  jss_pkg::t_result i_res,
    output logic             o_advance,
    output logic             o_valid,
    input  logic             i_stall,
    output jss_pkg::t_result o_res
);

    logic             r_valid;
    jss_pkg::t_result r_res;

    // advance when empty or when the held word is taken this cycle
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

@@ hdl/jtag_shift_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// jtag_shift_sequencer_core: JTAG master shift engine
// A start word loads one of six shift commands; each tick word issues one
// TCK pulse and returns the TDI/TMS levels, done flag and captured reply.
//
// Input channel (i_in_valid / o_in_stall): start and tick words. A word is
// taken on an edge with valid high and stall low. Words land in an input
// register, are processed combinationally, and the result goes to the output
// register. Start words and ticks while idle produce no result word.
// Output channel (o_out_valid / i_out_stall): one result per clocking tick.
// Throughput is one word per cycle. When the receiver stalls, the output
// register holds its word, the input register holds the next one, and
// o_in_stall rises until the output register frees up.
// Config channel (i_cfg_valid / o_cfg_ready): erase clock count, always
// ready; write it only while idle.
// Reset (i_rst_n low, synchronous) clears the command state, empties both
// registers and loads the erase count with 360000.
// ----------------------------------------------------------------------------
module jtag_shift_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data,
    input  logic [3:0]  i_bit_count,
    input  logic [31:0] i_dr_word,
    input  logic [7:0]  i_tail,
    input  logic        i_tdo,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_clocked,
    output logic        o_tdi_out,
    output logic        o_tms_out,
    output logic        o_done_res,
    output logic [7:0]  o_reply,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic                        r_in_valid;
    jss_pkg::t_item              r_in_item;
    logic [jss_pkg::COUNT_W-1:0] r_erase_clocks;
    logic                        w_advance;
    logic                        w_fire;
    logic                        w_accept;
    logic                        w_res_valid;
    jss_pkg::t_result            w_res;
    jss_pkg::t_result            w_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_fire      = r_in_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_erase_clocks <= jss_pkg::COUNT_W'(jss_pkg::ERASE_RESET);
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_erase_clocks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= '{operation: i_operation, command: i_command, data: i_data,
                           bit_count: i_bit_count, dr_word: i_dr_word, tail: i_tail,
                           tdo: i_tdo};
        end
    end

    jss_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_item         (r_in_item),
        .i_erase_clocks (r_erase_clocks),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    jss_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_fire && w_res_valid),
        .i_res       (w_res),
        .o_advance   (w_advance),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_res       (w_out)
    );

    assign o_clocked  = w_out.clocked;
    assign o_tdi_out  = w_out.tdi_out;
    assign o_tms_out  = w_out.tms_out;
    assign o_done_res = w_out.done_res;
    assign o_reply    = w_out.reply;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the JTAG shift sequencer core
// Streams start and tick words into the engine and predicts every TCK pulse
// it reports: TDI/TMS levels, done flag and captured reply. The erase length
// is rewritten between phases, each time once the engine has gone idle. Both
// channels throttle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          PHASE_WORDS    = 226;
    localparam logic [23:0] ERASE_RUN_MAX  = 24'd48;
    localparam logic [2:0]  CMD_UNUSED     = 3'd6;
    localparam logic [2:0]  CMD_RESERVED   = 3'd7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_operation = 1'b0;
    logic [2:0]  i_command   = '0;
    logic [7:0]  i_data      = '0;
    logic [3:0]  i_bit_count = '0;
    logic [31:0] i_dr_word   = '0;
    logic [7:0]  i_tail      = '0;
    logic        i_tdo       = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [23:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_clocked;
    logic        o_tdi_out;
    logic        o_tms_out;
    logic        o_done_res;
    logic [7:0]  o_reply;
    logic        o_cfg_ready;

    // engine shadow state
    logic [2:0]                  eng_mode      = '0;
    logic                        eng_busy      = 1'b0;
    logic [jss_pkg::COUNT_W-1:0] eng_left      = '0;
    logic [31:0]                 eng_shift     = '0;
    logic [7:0]                  eng_capture   = '0;
    logic                        eng_last_tms  = 1'b0;
    logic                        eng_tdi       = 1'b0;
    logic                        eng_tms       = 1'b0;
    logic [jss_pkg::COUNT_W-1:0] erase_setting = jss_pkg::COUNT_W'(jss_pkg::ERASE_RESET);

    jss_pkg::t_item   word_q[$];
    jss_pkg::t_result pulse_q[$];
    jss_pkg::t_item   cur_word;
    int               words_queued  = 0;
    int               words_taken   = 0;
    int               send_gap      = 0;
    bit               send_burst    = 1'b0;
    int               recv_wait     = 0;
    bit               recv_burst    = 1'b0;
    int               mismatches    = 0;
    int unsigned      idle_cycles   = 0;

    jtag_shift_sequencer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_command   (i_command),
        .i_data      (i_data),
        .i_bit_count (i_bit_count),
        .i_dr_word   (i_dr_word),
        .i_tail      (i_tail),
        .i_tdo       (i_tdo),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_clocked   (o_clocked),
        .o_tdi_out   (o_tdi_out),
        .o_tms_out   (o_tms_out),
        .o_done_res  (o_done_res),
        .o_reply     (o_reply),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the shadow engine by one word and queue the pulse it reports.
    function automatic void predict_tck_step(input jss_pkg::t_item w);
        logic                        done;
        logic [jss_pkg::COUNT_W-1:0] count;
        jss_pkg::t_result            r;
        if (w.operation == jss_pkg::OP_START) begin
            if (!eng_busy && w.command <= jss_pkg::CMD_ERASE) begin
                eng_capture = '0;
                eng_shift   = {24'd0, w.data};
                count       = jss_pkg::COUNT_W'(w.bit_count);
                case (w.command)
                    jss_pkg::CMD_TMS_SHIFT: eng_tdi = w.data[7];
                    jss_pkg::CMD_DR32: begin
                        eng_shift = {w.dr_word[7:0], w.dr_word[15:8], w.dr_word[23:16],
                                     w.dr_word[31:25], w.tail[7]};
                        eng_last_tms = w.tail[0];
                        count        = jss_pkg::COUNT_W'(jss_pkg::DR_LENGTH);
                    end
                    jss_pkg::CMD_ERASE: begin
                        eng_tdi = 1'b0;
                        eng_tms = 1'b0;
                        count   = erase_setting;
                    end
                    default: ;
                endcase
                eng_mode = w.command;
                eng_left = count;
                eng_busy = (count != '0);
            end
        end else if (eng_busy) begin
            done = (eng_left == jss_pkg::COUNT_W'(1));
            case (eng_mode)
                jss_pkg::CMD_LSB_SHIFT: begin
                    eng_tdi     = eng_shift[0];
                    eng_shift   = {25'd0, eng_shift[7:1]};
                    eng_capture = {w.tdo, eng_capture[7:1]};
                end
                jss_pkg::CMD_MSB_SHIFT: begin
                    eng_tdi     = eng_shift[7];
                    eng_shift   = {24'd0, eng_shift[6:0], 1'b0};
                    eng_capture = {eng_capture[6:0], w.tdo};
                end
                jss_pkg::CMD_TMS_SHIFT: begin
                    eng_tms     = eng_shift[0];
                    eng_shift   = {25'd0, eng_shift[7:1]};
                    eng_capture = {w.tdo, eng_capture[7:1]};
                end
                jss_pkg::CMD_MSB_OUT: begin
                    eng_tdi   = eng_shift[7];
                    eng_shift = {24'd0, eng_shift[6:0], 1'b0};
                end
                jss_pkg::CMD_DR32: begin
                    eng_tdi   = eng_shift[31];
                    eng_shift = {eng_shift[30:0], 1'b0};
                    eng_tms   = done ? eng_last_tms : 1'b0;
                end
                default: begin
                    eng_tdi = 1'b0;
                    eng_tms = 1'b0;
                end
            endcase
            eng_left   = eng_left - jss_pkg::COUNT_W'(1);
            r.clocked  = 1'b1;
            r.tdi_out  = eng_tdi;
            r.tms_out  = eng_tms;
            r.done_res = done;
            r.reply    = '0;
            if (done) begin
                eng_busy = 1'b0;
                if (eng_mode <= jss_pkg::CMD_TMS_SHIFT) r.reply = eng_capture;
            end
            pulse_q.push_back(r);
        end
    endfunction

    // Input driver: one word per handshake, random gap between words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_tck_step(cur_word);
                words_taken++;
            end
            if (i_in_valid && o_in_stall) begin
                // hold the stalled word
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
                cur_word = word_q.pop_front();
                i_operation <= cur_word.operation;
                i_command   <= cur_word.command;
                i_data      <= cur_word.data;
                i_bit_count <= cur_word.bit_count;
                i_dr_word   <= cur_word.dr_word;
                i_tail      <= cur_word.tail;
                i_tdo       <= cur_word.tdo;
                i_in_valid  <= 1'b1;
                if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 3);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each taken word against the oldest prediction.
    always @(posedge i_clk) begin
        jss_pkg::t_result got;
        jss_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_clocked, o_tdi_out, o_tms_out, o_done_res, o_reply};
                if (pulse_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: clk=%0b tdi=%0b tms=%0b done=%0b reply=%02h",
                                 got.clocked, got.tdi_out, got.tms_out, got.done_res, got.reply);
                end else begin
                    want = pulse_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch want: clk=%0b tdi=%0b tms=%0b done=%0b reply=%02h",
                                     want.clocked, want.tdi_out, want.tms_out, want.done_res,
                                     want.reply);
                            $display("          got: clk=%0b tdi=%0b tms=%0b done=%0b reply=%02h",
                                     got.clocked, got.tdi_out, got.tms_out, got.done_res,
                                     got.reply);
                        end
                    end
                end
                if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 3);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Random word; starts never open a long erase burst.
    function automatic jss_pkg::t_item rand_word(input logic op);
        jss_pkg::t_item w;
        w.operation = op;
        w.command   = 3'($urandom_range(0, 7));
        w.data      = 8'($urandom_range(0, 255));
        w.bit_count = 4'($urandom_range(0, 15));
        w.dr_word   = $urandom;
        w.tail      = 8'($urandom_range(0, 255));
        w.tdo       = 1'($urandom_range(0, 1));
        if (w.command == jss_pkg::CMD_ERASE && erase_setting > ERASE_RUN_MAX)
            w.command = CMD_UNUSED;
        return w;
    endfunction

    function automatic jss_pkg::t_item cmd_word(input logic [2:0] cmd, input logic [7:0] data,
                                                input logic [3:0] count);
        jss_pkg::t_item w;
        w           = rand_word(jss_pkg::OP_START);
        w.command   = cmd;
        w.data      = data;
        w.bit_count = count;
        return w;
    endfunction

    task automatic queue_word(input jss_pkg::t_item w);
        word_q.push_back(w);
        words_queued++;
    endtask

    task automatic queue_ticks(input int n);
        for (int k = 0; k < n; k++) queue_word(rand_word(jss_pkg::OP_TICK));
    endtask

    // Mostly complete commands; some cut short, some stray words.
    task automatic queue_sequence(output int n_words);
        jss_pkg::t_item w;
        logic [2:0]     cmd;
        int             n_ticks;
        int             roll;
        roll    = $urandom_range(0, 99);
        n_words = 0;
        if (roll < 93) begin
            cmd = 3'($urandom_range(0, 5));
            if (cmd == jss_pkg::CMD_ERASE && erase_setting > ERASE_RUN_MAX)
                cmd = jss_pkg::CMD_DR32;
            w = cmd_word(cmd, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 8)));
            if ($urandom_range(0, 9) == 0) w.bit_count = 4'($urandom_range(9, 15));
            case ($urandom_range(0, 7))
                0: w.dr_word = '0;
                1: w.dr_word = '1;
                default: ;
            endcase
            queue_word(w);
            n_ticks = (cmd == jss_pkg::CMD_DR32)  ? jss_pkg::DR_LENGTH :
                      (cmd == jss_pkg::CMD_ERASE) ? int'(erase_setting) : int'(w.bit_count);
            // cut the command short
            if (roll >= 85 && n_ticks > 0) n_ticks = $urandom_range(0, n_ticks - 1);
            n_words = n_ticks + 1;
            for (int k = 0; k < n_ticks; k++) begin
                // drop in a start that the busy engine must ignore
                if ($urandom_range(0, 39) == 0) queue_word(rand_word(jss_pkg::OP_START));
                queue_word(rand_word(jss_pkg::OP_TICK));
            end
            if ($urandom_range(0, 7) == 0) queue_word(rand_word(jss_pkg::OP_TICK));
        end else begin
            queue_word(rand_word(1'($urandom_range(0, 1))));
        end
    endtask

    // Let every word drain, finish any open command, then wait out latency.
    task automatic finish_phase();
        while (words_taken != words_queued) @(posedge i_clk);
        while (eng_busy) begin
            queue_ticks(int'(eng_left));
            while (words_taken != words_queued) @(posedge i_clk);
        end
        while (pulse_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_erase_clocks(input logic [23:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        erase_setting  = value;
    endtask

    initial begin : stimulus
        logic [23:0] settings[5];
        int          phase_words;
        int          n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corner cases with a one-pulse erase
        write_erase_clocks(24'd1);
        queue_ticks(1);
        queue_word(cmd_word(jss_pkg::CMD_LSB_SHIFT, 8'hFF, 4'd0));
        queue_word(cmd_word(jss_pkg::CMD_TMS_SHIFT, 8'h80, 4'd0));
        queue_word(cmd_word(CMD_UNUSED, 8'h00, 4'd8));
        queue_word(cmd_word(CMD_RESERVED, 8'hFF, 4'd15));
        queue_word(cmd_word(jss_pkg::CMD_ERASE, 8'h00, 4'd0));
        queue_ticks(1);
        queue_word(cmd_word(jss_pkg::CMD_MSB_SHIFT, 8'hA5, 4'd2));
        queue_word(cmd_word(jss_pkg::CMD_LSB_SHIFT, 8'hFF, 4'd8));
        queue_ticks(2);
        queue_word(cmd_word(jss_pkg::CMD_LSB_SHIFT, 8'h01, 4'd9));
        queue_ticks(10);
        finish_phase();

        settings[0] = 24'hFFFFFF;
        settings[1] = 24'd3;
        settings[2] = 24'($urandom_range(2, 40));
        settings[3] = 24'd1;
        settings[4] = 24'($urandom_range(4, 16));
        foreach (settings[p]) begin
            write_erase_clocks(settings[p]);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                queue_sequence(n);
                phase_words += n;
            end
            finish_phase();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
